// ----- rtl/core/tbrl_pkg.sv -----
// Package for the token bucket rate limiter: widths, register indexes,
// reset values, the controller state type and the divider status struct.
// No dependencies.
package tbrl_pkg;

  localparam int TIME_BITS      = 64;                 // timestamp bits used, 32..64
  localparam int REQ_TIME_BITS  = 64;                 // width of the request_time field
  localparam int BUCKET_BITS    = 16;
  localparam int INTERVAL_BITS  = 30;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 30;
  localparam int CNT_BITS       = $clog2(TIME_BITS + 1);

  localparam longint unsigned NS_PER_SECOND = 64'd1000000000;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BUCKET_SIZE     = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REFILL_INTERVAL = 1'd1;

  localparam logic [BUCKET_BITS-1:0]   RESET_BUCKET   = 16'd100;
  localparam logic [INTERVAL_BITS-1:0] RESET_INTERVAL = INTERVAL_BITS'(NS_PER_SECOND / 100);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } tbrl_state_t;

  // Status of the serial divider as seen by the controller.
  typedef struct packed {
    logic                   done;   // one-cycle pulse when the quotient is complete
    logic                   ovf;    // quotient does not fit in BUCKET_BITS
    logic [BUCKET_BITS-1:0] quot;   // low quotient bits, valid when ovf is clear
  } tbrl_div_stat_t;

endpackage

// ----- rtl/core/tbrl_if.sv -----
// Channel interfaces of the token bucket rate limiter: request input,
// result output and configuration write. Depends on tbrl_pkg.

interface tbrl_req_if;
  import tbrl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_TIME_BITS-1:0] request_time;
  modport source (output valid, output request_time, input ready);
  modport sink   (input valid, input request_time, output ready);
endinterface

interface tbrl_res_if;
  import tbrl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   granted;
  logic [BUCKET_BITS-1:0] tokens_left;
  modport source (output valid, output granted, output tokens_left, input ready);
  modport sink   (input valid, input granted, input tokens_left, output ready);
endinterface

interface tbrl_cfg_if;
  import tbrl_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/tbrl_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Keeps only the low quotient bits plus a sticky overflow. Depends on tbrl_pkg.
module tbrl_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [tbrl_pkg::TIME_BITS-1:0]       dividend,
  input  logic [tbrl_pkg::INTERVAL_BITS-1:0]   divisor,
  output tbrl_pkg::tbrl_div_stat_t             stat
);
  import tbrl_pkg::*;

  logic [TIME_BITS-1:0]     dvd_r, dvd_nxt;
  logic [INTERVAL_BITS-1:0] dsr_r, dsr_nxt;
  logic [INTERVAL_BITS-1:0] rem_r, rem_nxt;
  logic [BUCKET_BITS-1:0]   quot_r, quot_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic                     done_r, done_nxt;

  logic [INTERVAL_BITS:0]   trial;
  logic [INTERVAL_BITS:0]   diff;
  logic                     fits;

  // Bring down the next dividend bit and try one subtraction.
  always_comb begin
    trial = {rem_r, dvd_r[TIME_BITS-1]};
    diff  = trial - {1'b0, dsr_r};
    fits  = (trial >= {1'b0, dsr_r});
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      quot_nxt = '0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = CNT_BITS'(TIME_BITS);
    end else if (cnt_r != '0) begin
      dvd_nxt  = {dvd_r[TIME_BITS-2:0], 1'b0};
      // The remainder stays below the divisor, so a failed trial never has its top bit set.
      rem_nxt  = fits ? diff[INTERVAL_BITS-1:0] : trial[INTERVAL_BITS-1:0];
      quot_nxt = {quot_r[BUCKET_BITS-2:0], fits};
      ovf_nxt  = ovf_r | quot_r[BUCKET_BITS-1];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign stat.quot = quot_r;

endmodule

// ----- rtl/core/token_bucket_rate_limiter.sv -----
// Top level of the token bucket rate limiter: controller, bucket state,
// configuration registers and result register. Depends on tbrl_pkg,
// the channel interfaces in tbrl_if.sv and the serial divider tbrl_div.

// Each request carries a nanosecond timestamp and gets exactly one result:
// granted, and the tokens left in the bucket afterwards. A request that finds
// a refill reference and a timestamp at or after it runs through a bit-serial
// divider that produces one quotient bit per clock in ST_DIVIDE; ST_FINISH
// then loads the result once the output register is free. The first
// request after reset or a register write, and one stamped before the
// reference, skip ST_DIVIDE and go to ST_FINISH. One request is processed at
// a time; the next one is accepted as soon as the previous result is placed
// in the output register, even while that result still waits to be taken.
// Writing either register refills the bucket to its size and forgets the
// reference, so the next request only sets the reference. Software programs
// refill_interval as one billion divided by the wanted rate; zero is taken
// as one nanosecond. Configuration writes are always accepted and are meant
// to be issued only while no request is in progress.
module token_bucket_rate_limiter (
  input logic         clk,
  input logic         rst_n,
  tbrl_req_if.sink    in_ch,
  tbrl_res_if.source  out_ch,
  tbrl_cfg_if.sink    cfg_ch
);
  import tbrl_pkg::*;

  tbrl_state_t              state_r, state_nxt;
  logic [BUCKET_BITS-1:0]   bucket_r, bucket_nxt;
  logic [INTERVAL_BITS-1:0] interval_r, interval_nxt;
  logic [BUCKET_BITS-1:0]   token_r, token_nxt;
  logic [TIME_BITS-1:0]     ref_r, ref_nxt;
  logic                     ref_valid_r, ref_valid_nxt;
  logic [TIME_BITS-1:0]     now_r, now_nxt;
  logic                     skip_r, skip_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_granted_r, out_granted_nxt;
  logic [BUCKET_BITS-1:0]   out_left_r, out_left_nxt;

  logic [TIME_BITS-1:0]     now;
  logic [TIME_BITS:0]       elapsed;
  logic                     early;
  logic [INTERVAL_BITS-1:0] step;
  logic                     in_acc;
  logic                     cfg_acc;
  logic                     div_start;
  tbrl_div_stat_t           div_stat;

  logic                     refill;
  logic [BUCKET_BITS:0]     sum;
  logic [BUCKET_BITS-1:0]   base;
  logic                     grant;
  logic [BUCKET_BITS-1:0]   left;
  logic                     load;
  logic                     in_ready;

  // Request side: elapsed time since the reference, and the zero-interval fix-up.
  always_comb begin
    now       = in_ch.request_time[TIME_BITS-1:0];
    elapsed   = {1'b0, now} - {1'b0, ref_r};
    early     = elapsed[TIME_BITS];
    step      = (interval_r == '0) ? INTERVAL_BITS'(1) : interval_r;
    in_acc    = in_ch.valid & in_ready;
    cfg_acc   = cfg_ch.valid & cfg_ch.ready;
    div_start = in_acc & ref_valid_r & ~early;
  end

  tbrl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed[TIME_BITS-1:0]),
    .divisor  (step),
    .stat     (div_stat)
  );

  // Refill and grant. A zero quotient means less than one interval has passed,
  // in which case no tokens are added and the reference does not move.
  always_comb begin
    refill = ~skip_r & (div_stat.ovf | (div_stat.quot != '0));
    sum    = {1'b0, token_r} + {1'b0, div_stat.quot};
    if (!refill) begin
      base = token_r;
    end else if (div_stat.ovf || (sum > {1'b0, bucket_r})) begin
      base = bucket_r;
    end else begin
      base = sum[BUCKET_BITS-1:0];
    end
    grant = (base != '0);
    left  = base - BUCKET_BITS'(grant);
  end

  // Next state of the controller.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = div_start ? ST_DIVIDE : ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_DIVIDE: in_ready = 1'b0;
      ST_FINISH: load     = ~out_valid_r | out_ch.ready;
      default:   in_ready = 1'b0;
    endcase
  end

  // Bucket state, configuration registers and the result register.
  always_comb begin
    bucket_nxt      = bucket_r;
    interval_nxt    = interval_r;
    token_nxt       = token_r;
    ref_nxt         = ref_r;
    ref_valid_nxt   = ref_valid_r;
    now_nxt         = now_r;
    skip_nxt        = skip_r;
    out_granted_nxt = out_granted_r;
    out_left_nxt    = out_left_r;
    out_valid_nxt   = out_valid_r & ~out_ch.ready;

    if (in_acc) begin
      now_nxt  = now;
      skip_nxt = ~div_start;
      if (!ref_valid_r) begin
        // First request after reset or a register write only sets the reference.
        ref_nxt       = now;
        ref_valid_nxt = 1'b1;
      end
    end

    if (load) begin
      token_nxt       = left;
      out_granted_nxt = grant;
      out_left_nxt    = left;
      out_valid_nxt   = 1'b1;
      if (refill) begin
        ref_nxt = now_r;
      end
    end

    if (cfg_acc) begin
      unique case (cfg_ch.index)
        REG_BUCKET_SIZE: begin
          bucket_nxt = cfg_ch.data[BUCKET_BITS-1:0];
          token_nxt  = cfg_ch.data[BUCKET_BITS-1:0];
        end
        REG_REFILL_INTERVAL: begin
          interval_nxt = cfg_ch.data[INTERVAL_BITS-1:0];
          token_nxt    = bucket_r;
        end
        default: token_nxt = bucket_r;
      endcase
      ref_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bucket_r    <= RESET_BUCKET;
      interval_r  <= RESET_INTERVAL;
      token_r     <= RESET_BUCKET;
      ref_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bucket_r    <= bucket_nxt;
      interval_r  <= interval_nxt;
      token_r     <= token_nxt;
      ref_valid_r <= ref_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ref_r         <= ref_nxt;
    now_r         <= now_nxt;
    skip_r        <= skip_nxt;
    out_granted_r <= out_granted_nxt;
    out_left_r    <= out_left_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.granted     = out_granted_r;
  assign out_ch.tokens_left = out_left_r;

endmodule

// ----- rtl/core/tbrl_checker.sv -----
// Port-level checks for the token bucket rate limiter and the bind that
// attaches them to the top level. Depends on tbrl_pkg.
module tbrl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_granted,
  input logic [tbrl_pkg::BUCKET_BITS-1:0] out_tokens_left
);
  import tbrl_pkg::*;

  logic [1:0] pending_r, pending_nxt;
  logic       in_acc;
  logic       out_acc;

  always_comb begin
    in_acc      = in_valid & in_ready;
    out_acc     = out_valid & out_ready;
    pending_nxt = pending_r + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // A waiting result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted) && $stable(out_tokens_left))
    else $error("result changed while stalled");

  // One request is processed at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // A refused request means the bucket was empty.
  a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_tokens_left == '0)
    else $error("refused request with tokens left");

  // Every result belongs to an accepted request.
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result without a pending request");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_granted     (out_ch.granted),
  .out_tokens_left (out_ch.tokens_left)
);
